// ===== hdl/chgw_pkg.sv =====
// Shared types and constants for the gift-wrap hull unit.
package chgw_pkg;

  // Upper bound on vertices returned by one walk, and its counter width.
  localparam int MAX_RESULTS = 16;
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,     // loading points
    ST_CAND_RD,  // read first candidate for current vertex
    ST_CAND_LD,  // candidate data back from store
    ST_Q_RD,     // read scan point
    ST_Q_GO,     // scan point back, launch orientation test
    ST_Q_WAIT,   // wait for orientation result, update candidate
    ST_EMIT      // present one hull vertex
  } state_t;

  // Orientation unit result.
  typedef struct packed {
    logic done;  // result valid this cycle
    logic turn;  // p, q, r turn counterclockwise: candidate must be replaced
  } orient_res_t;

endpackage

// ===== hdl/convex_hull_gift_wrap_unit.sv =====
// Top level of the 2-D convex hull unit (gift wrapping over a point store).
//
//  channel  | handshake          | payload                               | dir
//  ---------+--------------------+---------------------------------------+----
//  point    | start, busy        | point_x, point_y, set_last            | in
//  hull     | hull_valid         | hull_x, hull_y, hull_last, overflow   | out
//
// Points load at one per cycle: a transfer happens when start is high and busy
// low. The marked last point starts the walk and busy stays high until the
// final vertex has gone out.
// Walk: per hull vertex every stored point is scanned in turn, paced by the
// single read port of the point store and the three-stage orientation unit that each
// scan step waits on. Reset is synchronous and empties the set.
// hull_valid marks each vertex for one cycle; the receiver cannot stall.
module convex_hull_gift_wrap_unit
  import chgw_pkg::*;
#(
  parameter int MAX_POINTS = 16,
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic                         set_last,
  output logic                         hull_valid,
  output logic signed [COORD_BITS-1:0] hull_x,
  output logic signed [COORD_BITS-1:0] hull_y,
  output logic                         hull_last,
  output logic                         overflow
);

  localparam int IW = $clog2(MAX_POINTS);

  // store port wires
  logic                    ram_we, ram_re;
  logic [IW-1:0]           ram_waddr, ram_raddr;
  logic [2*COORD_BITS-1:0] ram_rdata;

  // current vertex (p) and candidate (r), held by the sequencer
  logic [COORD_BITS-1:0]   px, py, rx, ry;
  logic                    orient_go;
  orient_res_t             ores;

  // Point store: y in the upper half, x in the lower half of each entry.
  chgw_ram #(
    .WIDTH (2 * COORD_BITS),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({point_y, point_x}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Orientation of (p, q, r); q comes straight from the store read data,
  // which holds until the next read.
  chgw_orient #(
    .COORD_BITS (COORD_BITS)
  ) u_orient (
    .clk (clk),
    .rst (rst),
    .go  (orient_go),
    .px  (px),
    .py  (py),
    .qx  (ram_rdata[COORD_BITS-1:0]),
    .qy  (ram_rdata[2*COORD_BITS-1:COORD_BITS]),
    .rx  (rx),
    .ry  (ry),
    .res (ores)
  );

  // Sequencer: counts points, tracks the leftmost one while loading, then
  // scans every point per vertex and swaps the candidate on a counterclockwise turn.
  chgw_seq #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .point_x    (point_x),
    .point_y    (point_y),
    .set_last   (set_last),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .orient_go  (orient_go),
    .ores       (ores),
    .px         (px),
    .py         (py),
    .rx         (rx),
    .ry         (ry),
    .hull_valid (hull_valid),
    .hull_last  (hull_last),
    .overflow   (overflow)
  );

  // The vertex on the result ports is the current point of the walk.
  assign hull_x = px;
  assign hull_y = py;

  // A vertex only goes out during a walk.
  a_valid_in_walk: assert property (@(posedge clk) disable iff (rst)
    hull_valid |-> busy) else $error("hull_valid outside a walk");

  // The final vertex ends the walk.
  a_last_ends_walk: assert property (@(posedge clk) disable iff (rst)
    hull_valid && hull_last |=> !busy) else $error("walk did not end after last vertex");

  // Store writes only come from point transfers, never mid-walk.
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (start && !busy)) else $error("store written during a walk");

  // Orientation results only appear inside a walk.
  a_orient_in_walk: assert property (@(posedge clk) disable iff (rst)
    ores.done |-> busy) else $error("orientation result while idle");

  // Reset returns the unit to loading.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !busy) else $error("busy after reset");

endmodule

// ===== hdl/chgw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module chgw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/chgw_orient.sv =====
// Three-stage orientation test: differences, products, sign compare.
module chgw_orient
  import chgw_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         go,
  input  logic signed [COORD_BITS-1:0] px,
  input  logic signed [COORD_BITS-1:0] py,
  input  logic signed [COORD_BITS-1:0] qx,
  input  logic signed [COORD_BITS-1:0] qy,
  input  logic signed [COORD_BITS-1:0] rx,
  input  logic signed [COORD_BITS-1:0] ry,
  output orient_res_t                  res
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  logic              v1, v2, v3;
  logic signed [DW-1:0] dqy, drx, dqx, dry;
  logic signed [PW-1:0] t1, t2;
  logic              turn;

  // valid pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= go;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    dqy  <= DW'(qy) - DW'(py);
    drx  <= DW'(rx) - DW'(qx);
    dqx  <= DW'(qx) - DW'(px);
    dry  <= DW'(ry) - DW'(qy);
    t1   <= dqy * drx;
    t2   <= dqx * dry;
    turn <= (t1 < t2);   // t1 - t2 negative: p, q, r turn counterclockwise
  end

  assign res.done = v3;
  assign res.turn = turn;

endmodule

// ===== hdl/chgw_seq.sv =====
// Load and walk sequencer: point count, leftmost tracking, candidate scan.
module chgw_seq
  import chgw_pkg::*;
#(
  parameter int MAX_POINTS = 16,
  parameter int COORD_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [COORD_BITS-1:0]          point_x,
  input  logic [COORD_BITS-1:0]          point_y,
  input  logic                           set_last,
  output logic                           ram_we,
  output logic [$clog2(MAX_POINTS)-1:0]  ram_waddr,
  output logic                           ram_re,
  output logic [$clog2(MAX_POINTS)-1:0]  ram_raddr,
  input  logic [2*COORD_BITS-1:0]        ram_rdata,
  output logic                           orient_go,
  input  orient_res_t                    ores,
  output logic [COORD_BITS-1:0]          px,
  output logic [COORD_BITS-1:0]          py,
  output logic [COORD_BITS-1:0]          rx,
  output logic [COORD_BITS-1:0]          ry,
  output logic                           hull_valid,
  output logic                           hull_last,
  output logic                           overflow
);

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int EW = (CW > RES_W) ? CW : RES_W;

  state_t          state, state_next;
  logic [CW-1:0]   count;
  logic            dropped;
  logic [IW-1:0]   start_idx, cur_idx, cand_idx, scan_idx;
  logic [COORD_BITS-1:0] lm_x, lm_y;
  logic [EW-1:0]   emitted;

  logic            accept, store_ok, lm_take;
  logic [IW-1:0]   start_idx_next;
  logic [COORD_BITS-1:0] lm_x_next, lm_y_next;
  logic [CW-1:0]   cur_inc;
  logic [IW-1:0]   first_cand;
  logic            scan_end;
  logic [EW-1:0]   emitted_inc;
  logic            walk_end;
  logic [COORD_BITS-1:0] qx, qy;

  assign qx = ram_rdata[COORD_BITS-1:0];
  assign qy = ram_rdata[2*COORD_BITS-1:COORD_BITS];

  assign accept   = start && (state == ST_IDLE);
  assign store_ok = (count < CW'(MAX_POINTS));
  // leftmost so far; strict compare keeps the earliest on a tie
  assign lm_take  = store_ok &&
                    ((count == '0) || ($signed(point_x) < $signed(lm_x)));
  assign start_idx_next = lm_take ? count[IW-1:0] : start_idx;
  assign lm_x_next      = lm_take ? point_x : lm_x;
  assign lm_y_next      = lm_take ? point_y : lm_y;

  assign cur_inc    = CW'(cur_idx) + CW'(1);
  assign first_cand = (cur_inc == count) ? '0 : cur_inc[IW-1:0];
  assign scan_end   = (CW'(scan_idx) == (count - CW'(1)));

  assign emitted_inc = emitted + EW'(1);
  assign walk_end    = (cand_idx == start_idx) || (emitted_inc >= EW'(count)) ||
                       (emitted_inc >= EW'(MAX_RESULTS));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (accept && set_last) state_next = ST_CAND_RD;
      ST_CAND_RD: state_next = ST_CAND_LD;
      ST_CAND_LD: state_next = ST_Q_RD;
      ST_Q_RD:    state_next = ST_Q_GO;
      ST_Q_GO:    state_next = ST_Q_WAIT;
      ST_Q_WAIT: begin
        if (ores.done) state_next = scan_end ? ST_EMIT : ST_Q_RD;
      end
      ST_EMIT:    state_next = walk_end ? ST_IDLE : ST_CAND_RD;
      default:    state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy       = 1'b1;
    ram_re     = 1'b0;
    ram_raddr  = scan_idx;
    orient_go  = 1'b0;
    hull_valid = 1'b0;
    unique case (state)
      ST_IDLE:    busy = 1'b0;
      ST_CAND_RD: begin
        ram_re    = 1'b1;
        ram_raddr = first_cand;
      end
      ST_Q_RD:    ram_re = 1'b1;
      ST_Q_GO:    orient_go = 1'b1;
      ST_EMIT:    hull_valid = 1'b1;
      default:    busy = 1'b1;
    endcase
  end

  assign ram_we    = accept && store_ok;
  assign ram_waddr = count[IW-1:0];
  assign hull_last = walk_end;
  assign overflow  = dropped;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      dropped <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (store_ok) count <= count + CW'(1);
        else          dropped <= 1'b1;
      end
      if (state == ST_EMIT && walk_end) begin
        count   <= '0;
        dropped <= 1'b0;
      end
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      start_idx <= start_idx_next;
      lm_x      <= lm_x_next;
      lm_y      <= lm_y_next;
      cur_idx   <= start_idx_next;
      px        <= lm_x_next;
      py        <= lm_y_next;
      emitted   <= '0;
    end
    unique case (state)
      ST_CAND_RD: cand_idx <= first_cand;
      ST_CAND_LD: begin
        rx       <= qx;
        ry       <= qy;
        scan_idx <= '0;
      end
      ST_Q_WAIT: begin
        if (ores.done) begin
          if (ores.turn) begin
            cand_idx <= scan_idx;
            rx       <= qx;
            ry       <= qy;
          end
          scan_idx <= scan_idx + IW'(1);
        end
      end
      ST_EMIT: begin
        cur_idx <= cand_idx;
        px      <= rx;
        py      <= ry;
        emitted <= emitted_inc;
      end
      default: ;
    endcase
  end

endmodule
